@@ design/wrrqs_pkg.sv @@
// Shared types and constants for the weighted round-robin queue selector.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package wrrqs_pkg;

  // Default sizing
  localparam int NumQueuesDef  = 4;
  localparam int CreditBitsDef = 16;

  // Fixed field widths
  localparam int WeightRegs    = 4;   // queues that have a weight register
  localparam int WeightIdxBits = 2;   // $clog2(WeightRegs)
  localparam int WeightBits    = 8;
  localparam int MaskBits      = 4;
  localparam int CfgIndexBits  = 3;
  localparam int CfgDataBits   = 8;
  localparam int GrantBits     = 2;

  // Register map
  localparam logic [CfgIndexBits-1:0] RegWeightQ0  = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegBoostAmt  = 3'd4;

  // Request opcodes
  localparam logic OpSelect = 1'b0;
  localparam logic OpBoost  = 1'b1;

  typedef enum logic [1:0] {
    StatusGrant   = 2'd0,
    StatusNoGrant = 2'd1,
    StatusBoost   = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ design/wrrqs_search.sv @@
// Rotating priority search: first eligible queue after the start position.
// Depends on nothing but its parameter; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module wrrqs_search #(
  parameter int NumQueues = 4
) (
  input  wire logic [NumQueues-1:0]         elig_i,
  input  wire logic [$clog2(NumQueues)-1:0] start_i,
  output logic                              found_o,
  output logic [$clog2(NumQueues)-1:0]      index_o
);

  localparam int IdxW = $clog2(NumQueues);

  // pos[k-1] = (start + k) mod NumQueues, for k = 1..NumQueues
  logic [IdxW:0] pos_raw [NumQueues];
  logic [IdxW-1:0] pos [NumQueues];

  for (genvar k = 0; k < NumQueues; k++) begin : g_pos
    assign pos_raw[k] = {1'b0, start_i} + (IdxW+1)'(k + 1);
    always_comb begin
      if (pos_raw[k] >= (IdxW+1)'(NumQueues)) begin
        pos[k] = IdxW'(pos_raw[k] - (IdxW+1)'(NumQueues));
      end else begin
        pos[k] = pos_raw[k][IdxW-1:0];
      end
    end
  end

  // Walk from the farthest offset back so the nearest hit wins
  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    for (int k = NumQueues - 1; k >= 0; k--) begin
      if (elig_i[pos[k]]) begin
        found_o = 1'b1;
        index_o = pos[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/weighted_round_robin_queue_select.sv @@
// A request passes from the input register to the result register.
// Throughput: one request per cycle unless a held result stalls; credits and last
// grant update in the same cycle that the request leaves the input register, via
// two rotating searches (current credits, reloaded weights) in parallel.
// Reset: credits and last grant clear, weights go to 1, boost amount to 0.
// Uses wrrqs_pkg and wrrqs_search.
`timescale 1ns / 1ps
`default_nettype none

module weighted_round_robin_queue_select #(
  parameter int NumQueues  = wrrqs_pkg::NumQueuesDef,
  parameter int CreditBits = wrrqs_pkg::CreditBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // request channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 op_i,
  input  wire logic [wrrqs_pkg::MaskBits-1:0]       nonempty_mask_i,
  input  wire logic [wrrqs_pkg::MaskBits-1:0]       preferred_mask_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                status_o,
  output logic [wrrqs_pkg::GrantBits-1:0]           grant_index_o,
  // configuration
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [wrrqs_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  wire logic [wrrqs_pkg::CfgDataBits-1:0]    cfg_data_i
);

  localparam int IdxW = $clog2(NumQueues);

  // Configuration registers
  logic [wrrqs_pkg::WeightBits-1:0] weight_q [wrrqs_pkg::WeightRegs];
  logic [wrrqs_pkg::WeightBits-1:0] boost_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wrrqs_pkg::WeightRegs; i++) begin
        weight_q[i] <= wrrqs_pkg::WeightBits'(1);
      end
      boost_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i < wrrqs_pkg::RegBoostAmt) begin
        weight_q[cfg_index_i[wrrqs_pkg::WeightIdxBits-1:0]] <= cfg_data_i;
      end else if (cfg_index_i == wrrqs_pkg::RegBoostAmt) begin
        boost_q <= cfg_data_i;
      end
    end
  end

  // Input register
  logic                              a_valid_q;
  logic                              a_op_q;
  logic [wrrqs_pkg::MaskBits-1:0]    a_ne_q;
  logic [wrrqs_pkg::MaskBits-1:0]    a_pref_q;

  // Result register
  logic                              b_valid_q;
  wrrqs_pkg::status_e                b_status_q;
  logic [wrrqs_pkg::GrantBits-1:0]   b_grant_q;

  logic take_b;
  logic in_fire;

  assign take_b     = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !take_b;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (take_b) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_op_q   <= op_i;
      a_ne_q   <= nonempty_mask_i;
      a_pref_q <= preferred_mask_i;
    end
  end

  // Arbitration state
  logic [CreditBits-1:0] credit_q [NumQueues];
  logic [CreditBits-1:0] credit_d [NumQueues];
  logic [IdxW-1:0]       last_q;
  logic [IdxW-1:0]       last_d;

  logic [CreditBits-1:0] reload   [NumQueues];
  logic [CreditBits-1:0] boosted  [NumQueues];
  logic [CreditBits:0]   boost_sum [NumQueues];
  logic [NumQueues-1:0]  nonempty;
  logic [NumQueues-1:0]  preferred;
  logic [NumQueues-1:0]  elig_now;
  logic [NumQueues-1:0]  elig_reload;

  // Queues beyond the mask / weight registers are never active and reload to zero
  for (genvar q = 0; q < NumQueues; q++) begin : g_queue
    if (q < wrrqs_pkg::MaskBits) begin : g_masked
      assign nonempty[q]  = a_ne_q[q];
      assign preferred[q] = a_pref_q[q];
    end else begin : g_unmasked
      assign nonempty[q]  = 1'b0;
      assign preferred[q] = 1'b0;
    end

    if (q < wrrqs_pkg::WeightRegs) begin : g_weighted
      assign reload[q] = CreditBits'(weight_q[q]);
    end else begin : g_unweighted
      assign reload[q] = '0;
    end

    assign boost_sum[q] = {1'b0, credit_q[q]} + (CreditBits+1)'(boost_q);
    assign boosted[q]   = !preferred[q]        ? credit_q[q] :
                          boost_sum[q][CreditBits] ? '1 :
                          boost_sum[q][CreditBits-1:0];

    assign elig_now[q]    = nonempty[q] && (credit_q[q] != '0);
    assign elig_reload[q] = nonempty[q] && (reload[q] != '0);
  end

  logic            found_now;
  logic [IdxW-1:0] idx_now;
  logic            found_reload;
  logic [IdxW-1:0] idx_reload;

  wrrqs_search #(
    .NumQueues (NumQueues)
  ) u_search_now (
    .elig_i  (elig_now),
    .start_i (last_q),
    .found_o (found_now),
    .index_o (idx_now)
  );

  wrrqs_search #(
    .NumQueues (NumQueues)
  ) u_search_reload (
    .elig_i  (elig_reload),
    .start_i (last_q),
    .found_o (found_reload),
    .index_o (idx_reload)
  );

  wrrqs_pkg::status_e              res_status;
  logic [wrrqs_pkg::GrantBits-1:0] res_grant;

  always_comb begin
    for (int q = 0; q < NumQueues; q++) begin
      credit_d[q] = credit_q[q];
    end
    last_d     = last_q;
    res_status = wrrqs_pkg::StatusGrant;
    res_grant  = '0;

    if (a_op_q == wrrqs_pkg::OpBoost) begin
      for (int q = 0; q < NumQueues; q++) begin
        credit_d[q] = boosted[q];
      end
      res_status = wrrqs_pkg::StatusBoost;
    end else if (found_now) begin
      for (int q = 0; q < NumQueues; q++) begin
        if (IdxW'(q) == idx_now) begin
          credit_d[q] = credit_q[q] - CreditBits'(1);
        end
      end
      last_d    = idx_now;
      res_grant = wrrqs_pkg::GrantBits'(idx_now);
    end else begin
      // Nothing eligible: reload every credit, then retry from the same start
      for (int q = 0; q < NumQueues; q++) begin
        credit_d[q] = reload[q];
        if (found_reload && (IdxW'(q) == idx_reload)) begin
          credit_d[q] = reload[q] - CreditBits'(1);
        end
      end
      if (found_reload) begin
        last_d    = idx_reload;
        res_grant = wrrqs_pkg::GrantBits'(idx_reload);
      end else begin
        res_status = wrrqs_pkg::StatusNoGrant;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NumQueues; q++) begin
        credit_q[q] <= '0;
      end
      last_q <= '0;
    end else if (take_b) begin
      for (int q = 0; q < NumQueues; q++) begin
        credit_q[q] <= credit_d[q];
      end
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (take_b) begin
      b_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_b) begin
      b_status_q <= res_status;
      b_grant_q  <= res_grant;
    end
  end

  assign out_valid_o   = b_valid_q;
  assign status_o      = b_status_q;
  assign grant_index_o = b_grant_q;

endmodule

`default_nettype wire

@@ design/wrrqs_checker.sv @@
// Port-level checker for the weighted round-robin queue selector, with its bind.
// Uses wrrqs_pkg for field widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module wrrqs_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [1:0]                         status_o,
  input wire logic [wrrqs_pkg::GrantBits-1:0]    grant_index_o
);

  // A held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(grant_index_o))
    else $error("result changed while stalled");

  // Requests back up only when the result slot is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == wrrqs_pkg::StatusGrant) ||
                    (status_o == wrrqs_pkg::StatusNoGrant) ||
                    (status_o == wrrqs_pkg::StatusBoost))
    else $error("undefined status code");

  a_no_grant_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != wrrqs_pkg::StatusGrant) |-> grant_index_o == '0)
    else $error("grant index set without a grant");

endmodule

bind weighted_round_robin_queue_select wrrqs_checker u_wrrqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .grant_index_o (grant_index_o)
);

`default_nettype wire
